>>> sv/lidar_point_camera_projection_macros.svh
// Assertion macros shared by the lidar point camera projection RTL.
`ifndef LIDAR_POINT_CAMERA_PROJECTION_MACROS_SVH
`define LIDAR_POINT_CAMERA_PROJECTION_MACROS_SVH
`ifndef ASSERT_OFF
`define LPCP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lpcp assertion failed");
`define LPCP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("lpcp assertion failed");
`else
`define LPCP_ASSERT(lbl, prop)
`define LPCP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> sv/lpcp_pkg.sv
// Shared types, constants and fixed-point helpers for the projection block.
package lpcp_pkg;

  localparam int CW       = 38;   // camera coordinate width
  localparam int QW       = 32;   // normalized / distortion value width
  localparam int DW       = 70;   // divider working width
  localparam int FRAC     = 20;
  localparam int DIV_DEPTH = QW + 2;
  localparam int NS       = 15;   // back-end arithmetic stages
  localparam int FIFO_DEPTH_DEF = 4;

  localparam logic signed [63:0] QMAX = 64'sd2147483647;

  localparam logic [62:0] ROT0_RST = 63'd524288;
  localparam logic [62:0] ROT1_RST = 63'd1099511627776;
  localparam logic [62:0] ROT2_RST = 63'd2305843009213693952;
  localparam logic [42:0] TANG_RST = 43'd4398046511104;

  typedef enum logic [2:0] {
    REG_ROT0, REG_ROT1, REG_ROT2, REG_OFF, REG_LENS, REG_RAD, REG_TANG
  } reg_idx_t;

  typedef struct packed {
    logic signed [2:0][2:0][20:0] rot;
    logic signed [2:0][20:0]      off;
    logic signed [QW-1:0]         k1;
    logic signed [QW-1:0]         k2;
    logic signed [QW-1:0]         k3;
    logic signed [QW-1:0]         p1;
    logic signed [QW-1:0]         p2;
    logic [15:0]                  fx;
    logic [15:0]                  fy;
    logic [15:0]                  cx;
    logic [15:0]                  cy;
    logic                         dist_en;
  } cfg_t;

  typedef struct packed {
    logic signed [CW-1:0] c0;
    logic signed [CW-1:0] c1;
    logic signed [CW-1:0] c2;
    logic [15:0]          inten;
    logic                 fault;
  } pt_t;

  typedef struct packed {
    logic                 fault;
    logic [15:0]          inten;
    logic signed [QW-1:0] xn, yn, x2, y2, xy, r2, tx, ty;
    logic signed [QW-1:0] r4, k1r2, pxy1, pxy2, ptx, pty, r6, k2r4, k3r6, rad, xd, yd;
    logic signed [63:0]   m0, m1, m2, m3;
    logic signed [19:0]   u, v;
  } bk_t;

  function automatic logic signed [63:0] w64(input logic signed [QW-1:0] a);
    return {{(64-QW){a[QW-1]}}, a};
  endfunction

  function automatic logic signed [QW-1:0] sat(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v;
    if (v > QMAX) t = QMAX;
    if (v < -QMAX) t = -QMAX;
    return t[QW-1:0];
  endfunction

  // Round half up at the 2^-20 position, then saturate.
  function automatic logic signed [QW-1:0] rs(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd524288) >>> FRAC;
    return sat(t);
  endfunction

  function automatic logic signed [19:0] to_pix(input logic signed [63:0] p,
                                                input logic [15:0] c);
    logic signed [63:0] t;
    t = ((p + 64'sd524288) >>> FRAC) + $signed({48'd0, c});
    if (t > 64'sd524287) t = 64'sd524287;
    if (t < -64'sd524288) t = -64'sd524288;
    return t[19:0];
  endfunction

endpackage

>>> sv/lpcp_fifo.sv
// Short queue between the front end and the arithmetic back end.
`include "lidar_point_camera_projection_macros.svh"
module lpcp_fifo import lpcp_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  pt_t  din,
  input  logic pop,
  output pt_t  dout,
  output logic full,
  output logic empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  pt_t mem_r [DEPTH];
  logic [PW-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= din;
  end

  `LPCP_ASSERT(a_cnt_bound, cnt_r <= CNW'(DEPTH))
  `LPCP_ASSERT(a_push_grows, (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
  `LPCP_ASSERT(a_pop_shrinks, (pop && !push) |=> (cnt_r == $past(cnt_r) - 1'b1))
endmodule

>>> sv/lpcp_front.sv
// Front end: accepts points, drops those behind the sensor, computes camera coordinates.
module lpcp_front import lpcp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               push,
  output logic               full,
  input  logic signed [23:0] pt_x,
  input  logic signed [23:0] pt_y,
  input  logic signed [23:0] pt_z,
  input  logic [15:0]        pt_inten,
  input  logic               q_full,
  output logic               q_push,
  output pt_t                q_data
);
  logic f1_v_r, f2_v_r, fe;
  logic signed [44:0] prod_r [3][3];
  logic [15:0] f1_inten_r;
  pt_t f2_r, f2_nxt;
  logic signed [46:0] acc [3];
  logic signed [CW-1:0] cc [3];

  assign fe     = !f2_v_r || !q_full;
  assign full   = !fe;
  assign q_push = f2_v_r && !q_full;
  assign q_data = f2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = 47'(prod_r[i][0]) + 47'(prod_r[i][1]) + 47'(prod_r[i][2]) +
               (47'($signed(cfg.off[i])) <<< 19);
      cc[i]  = CW'((acc[i] + 47'sd256) >>> 9);
    end
    f2_nxt.c0    = cc[0];
    f2_nxt.c1    = cc[1];
    f2_nxt.c2    = cc[2];
    f2_nxt.inten = f1_inten_r;
    f2_nxt.fault = (cc[2] <= 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (fe) begin
      f1_v_r <= push && !pt_x[23];
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      for (int i = 0; i < 3; i++) begin
        prod_r[i][0] <= $signed(cfg.rot[i][0]) * pt_x;
        prod_r[i][1] <= $signed(cfg.rot[i][1]) * pt_y;
        prod_r[i][2] <= $signed(cfg.rot[i][2]) * pt_z;
      end
      f1_inten_r <= pt_inten;
      f2_r       <= f2_nxt;
    end
  end
endmodule

>>> sv/lpcp_div.sv
// Pipelined restoring divider giving the saturated normalized coordinate num/den.
module lpcp_div import lpcp_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] num,
  input  logic [CW-2:0]        den,
  output logic signed [QW-1:0] quo
);
  localparam int QB  = QW - 1;
  localparam int NST = QB + 1;

  logic [DW-1:0] rem_r [NST+1];
  logic [CW-2:0] den_r [NST+1];
  logic [QB-1:0] q_r   [NST+1];
  logic          neg_r [NST+1];
  logic          sat_r [NST+1];
  logic signed [QW-1:0] quo_r;
  logic [CW-1:0] mag;
  logic [QW-1:0] qv;

  assign mag = num[CW-1] ? CW'(-num) : CW'(num);
  assign qv  = sat_r[NST] ? QW'(QMAX) : {1'b0, q_r[NST]};
  assign quo = quo_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(mag) << FRAC;
      den_r[0] <= den;
      q_r[0]   <= '0;
      neg_r[0] <= num[CW-1];
      sat_r[0] <= 1'b0;
      quo_r    <= neg_r[NST] ? -$signed(qv) : $signed(qv);
    end
  end

  for (genvar s = 1; s <= NST; s++) begin : g_st
    localparam int K = NST - s;
    logic [DW-1:0] dsh;
    logic ge;
    assign dsh = DW'(den_r[s-1]) << K;
    assign ge  = rem_r[s-1] >= dsh;
    if (s == 1) begin : g_sat
      // Quotient would need 32 bits: saturate.
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_r[s-1];
          q_r[s]   <= q_r[s-1];
          sat_r[s] <= ge;
          den_r[s] <= den_r[s-1];
          neg_r[s] <= neg_r[s-1];
        end
      end
    end else begin : g_bit
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= ge ? rem_r[s-1] - dsh : rem_r[s-1];
          q_r[s]   <= ge ? (q_r[s-1] | (QB'(1) << K)) : q_r[s-1];
          sat_r[s] <= sat_r[s-1];
          den_r[s] <= den_r[s-1];
          neg_r[s] <= neg_r[s-1];
        end
      end
    end
  end
endmodule

>>> sv/lpcp_back.sv
// Back end: division, lens distortion and pixel mapping, with the output register.
module lpcp_back import lpcp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_ok,
  input  pt_t                q_data,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic signed [19:0] pixel_u,
  output logic signed [19:0] pixel_v,
  output logic [15:0]        inten_out,
  output logic               fault_out
);
  logic be;
  logic signed [QW-1:0] qx, qy;
  logic        sb_v_r [DIV_DEPTH];
  logic        sb_f_r [DIV_DEPTH];
  logic [15:0] sb_i_r [DIV_DEPTH];
  logic vld_r [1:NS];
  bk_t  st_r  [1:NS];
  bk_t  nx    [1:NS];

  assign be        = !vld_r[NS] || pop;
  assign q_pop     = be && q_ok;
  assign empty     = !vld_r[NS];
  assign pixel_u   = st_r[NS].u;
  assign pixel_v   = st_r[NS].v;
  assign inten_out = st_r[NS].inten;
  assign fault_out = st_r[NS].fault;

  lpcp_div u_div_x (.clk, .en(be), .num(q_data.c0), .den(q_data.c2[CW-2:0]), .quo(qx));
  lpcp_div u_div_y (.clk, .en(be), .num(q_data.c1), .den(q_data.c2[CW-2:0]), .quo(qy));

  always_comb begin
    nx[1]       = '0;
    nx[1].fault = sb_f_r[DIV_DEPTH-1];
    nx[1].inten = sb_i_r[DIV_DEPTH-1];
    nx[1].xn    = sb_f_r[DIV_DEPTH-1] ? '0 : qx;
    nx[1].yn    = sb_f_r[DIV_DEPTH-1] ? '0 : qy;
    nx[1].m0    = nx[1].xn * nx[1].xn;
    nx[1].m1    = nx[1].yn * nx[1].yn;
    nx[1].m2    = nx[1].xn * nx[1].yn;
    for (int s = 2; s <= NS; s++) nx[s] = st_r[s-1];

    nx[2].x2 = rs(st_r[1].m0);
    nx[2].y2 = rs(st_r[1].m1);
    nx[2].xy = rs(st_r[1].m2);

    nx[3].r2 = sat(w64(st_r[2].x2) + w64(st_r[2].y2));

    nx[4].tx = sat(w64(st_r[3].r2) + w64(st_r[3].x2) + w64(st_r[3].x2));
    nx[4].ty = sat(w64(st_r[3].r2) + w64(st_r[3].y2) + w64(st_r[3].y2));
    nx[4].m0 = st_r[3].r2 * st_r[3].r2;
    nx[4].m1 = cfg.k1 * st_r[3].r2;
    nx[4].m2 = cfg.p1 * st_r[3].xy;
    nx[4].m3 = cfg.p2 * st_r[3].xy;

    nx[5].r4   = rs(st_r[4].m0);
    nx[5].k1r2 = rs(st_r[4].m1);
    nx[5].pxy1 = rs(st_r[4].m2);
    nx[5].pxy2 = rs(st_r[4].m3);
    nx[5].m0   = cfg.p2 * st_r[4].tx;
    nx[5].m1   = cfg.p1 * st_r[4].ty;

    nx[6].ptx = rs(st_r[5].m0);
    nx[6].pty = rs(st_r[5].m1);
    nx[6].m2  = st_r[5].r4 * st_r[5].r2;
    nx[6].m3  = cfg.k2 * st_r[5].r4;

    nx[7].r6   = rs(st_r[6].m2);
    nx[7].k2r4 = rs(st_r[6].m3);

    nx[8].m0 = cfg.k3 * st_r[7].r6;

    nx[9].k3r6 = rs(st_r[8].m0);

    nx[10].rad = sat(64'sd1048576 + w64(st_r[9].k1r2) + w64(st_r[9].k2r4) +
                     w64(st_r[9].k3r6));

    nx[11].m0 = st_r[10].xn * st_r[10].rad;
    nx[11].m1 = st_r[10].yn * st_r[10].rad;

    nx[12].xd = rs(st_r[11].m0);
    nx[12].yd = rs(st_r[11].m1);

    if (cfg.dist_en) begin
      nx[13].xd = sat(w64(st_r[12].xd) + w64(st_r[12].pxy1) + w64(st_r[12].pxy1) +
                      w64(st_r[12].ptx));
      nx[13].yd = sat(w64(st_r[12].yd) + w64(st_r[12].pty) + w64(st_r[12].pxy2) +
                      w64(st_r[12].pxy2));
    end else begin
      nx[13].xd = st_r[12].xn;
      nx[13].yd = st_r[12].yn;
    end

    nx[14].m0 = $signed({1'b0, cfg.fx}) * st_r[13].xd;
    nx[14].m1 = $signed({1'b0, cfg.fy}) * st_r[13].yd;

    // A point at or behind the camera plane reports a zero pixel.
    nx[15].u = st_r[14].fault ? '0 : to_pix(st_r[14].m0, cfg.cx);
    nx[15].v = st_r[14].fault ? '0 : to_pix(st_r[14].m1, cfg.cy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_DEPTH; k++) sb_v_r[k] <= 1'b0;
      for (int s = 1; s <= NS; s++) vld_r[s] <= 1'b0;
    end else if (be) begin
      sb_v_r[0] <= q_ok;
      for (int k = 1; k < DIV_DEPTH; k++) sb_v_r[k] <= sb_v_r[k-1];
      vld_r[1] <= sb_v_r[DIV_DEPTH-1];
      for (int s = 2; s <= NS; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      sb_f_r[0] <= q_data.fault;
      sb_i_r[0] <= q_data.inten;
      for (int k = 1; k < DIV_DEPTH; k++) begin
        sb_f_r[k] <= sb_f_r[k-1];
        sb_i_r[k] <= sb_i_r[k-1];
      end
      for (int s = 1; s <= NS; s++) st_r[s] <= nx[s];
    end
  end
endmodule

>>> sv/lidar_point_camera_projection.sv
// Lidar point to camera pixel projection, top level.
//
// Input queue port: present a point on in_point_* with push; it is taken on a
// clock edge where push is high and full is low. Points with negative x are
// taken and dropped. Output queue port: while empty is low the oldest pixel
// beat sits on out_*; pop high with empty low takes it.
// Configuration: cfg_we writes cfg_data into register cfg_index (0..6) at the
// clock edge; index 7 is ignored. Write only while no points are in flight.
// Throughput is one point per clock while the consumer keeps popping. A point
// passes the front-end product and coordinate registers, the queue, the
// bit-per-stage divider and the distortion and pixel pipeline.
// When the consumer stalls, the back pipeline holds as a whole; the queue
// then fills and full rises once the front end also holds a point.
// Reset (rst_n low, synchronous) empties all stages and the queue and loads
// identity rotation, zero offset, zero intrinsics and distortion enabled.
module lidar_point_camera_projection import lpcp_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [23:0] in_point_x,
  input  logic signed [23:0] in_point_y,
  input  logic signed [23:0] in_point_z,
  input  logic [15:0]        in_point_intensity,
  output logic               empty,
  input  logic               pop,
  output logic signed [19:0] out_pixel_u,
  output logic signed [19:0] out_pixel_v,
  output logic [15:0]        out_intensity_out,
  output logic               out_depth_fault,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  logic [62:0] rot0_r, rot1_r, rot2_r, off_r, rad_r;
  logic [63:0] lens_r;
  logic [42:0] tang_r;
  cfg_t cfg;
  logic q_push, q_pop, q_full, q_empty;
  pt_t  q_in, q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot0_r <= ROT0_RST;
      rot1_r <= ROT1_RST;
      rot2_r <= ROT2_RST;
      off_r  <= '0;
      lens_r <= '0;
      rad_r  <= '0;
      tang_r <= TANG_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ROT0: rot0_r <= cfg_data[62:0];
        REG_ROT1: rot1_r <= cfg_data[62:0];
        REG_ROT2: rot2_r <= cfg_data[62:0];
        REG_OFF:  off_r  <= cfg_data[62:0];
        REG_LENS: lens_r <= cfg_data;
        REG_RAD:  rad_r  <= cfg_data[62:0];
        REG_TANG: tang_r <= cfg_data[42:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cfg.rot[0][j] = rot0_r[21*j +: 21];
      cfg.rot[1][j] = rot1_r[21*j +: 21];
      cfg.rot[2][j] = rot2_r[21*j +: 21];
      cfg.off[j]    = off_r[21*j +: 21];
    end
    // Q4.17 coefficients widen to 20 fraction bits.
    cfg.k1 = {{8{rad_r[20]}}, rad_r[20:0], 3'b000};
    cfg.k2 = {{8{rad_r[41]}}, rad_r[41:21], 3'b000};
    cfg.k3 = {{8{rad_r[62]}}, rad_r[62:42], 3'b000};
    cfg.p1 = {{8{tang_r[20]}}, tang_r[20:0], 3'b000};
    cfg.p2 = {{8{tang_r[41]}}, tang_r[41:21], 3'b000};
    cfg.fx = lens_r[15:0];
    cfg.fy = lens_r[31:16];
    cfg.cx = lens_r[47:32];
    cfg.cy = lens_r[63:48];
    cfg.dist_en = tang_r[42];
  end

  lpcp_front u_front (
    .clk, .rst_n, .cfg, .push, .full,
    .pt_x(in_point_x), .pt_y(in_point_y), .pt_z(in_point_z),
    .pt_inten(in_point_intensity),
    .q_full, .q_push, .q_data(q_in)
  );

  lpcp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk, .rst_n, .push(q_push), .din(q_in), .pop(q_pop), .dout(q_out),
    .full(q_full), .empty(q_empty)
  );

  lpcp_back u_back (
    .clk, .rst_n, .cfg, .q_ok(!q_empty), .q_data(q_out), .q_pop,
    .pop, .empty,
    .pixel_u(out_pixel_u), .pixel_v(out_pixel_v),
    .inten_out(out_intensity_out), .fault_out(out_depth_fault)
  );
endmodule
